FILE: hdl/block_hash_128_absorb_top_assert.svh
// ----------------------------------------------------------------------------
// block_hash_128_absorb_top_assert.svh
// Assertion macros for the block hash absorb engine, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_HASH_128_ABSORB_TOP_ASSERT_SVH
`define BLOCK_HASH_128_ABSORB_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("block hash assertion failed");
// next-cycle implication
`define BH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("block hash assertion failed");
`else
`define BH_ASSERT_IMP(label, ante, cons)
`define BH_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: hdl/bhash_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhash_pkg
// Constants, datapath op codes and helpers shared by the block hash engine.
// ----------------------------------------------------------------------------
package bhash_pkg;

  localparam logic [31:0] SEED_A   = 32'h5a44f074;
  localparam logic [31:0] SEED_B   = 32'h35e820f6;
  localparam logic [31:0] SEED_C   = 32'h674f1845;
  localparam logic [31:0] SEED_D   = 32'h7fb5de7f;
  localparam logic [31:0] K_A      = 32'h1b873593;
  localparam logic [31:0] K_C      = 32'h0f7527d9;
  localparam logic [31:0] K_D      = 32'h0356ac85;
  localparam logic [31:0] MX_ADD   = 32'h28330d1b;
  localparam logic [31:0] MX_MUL   = 32'h483b86d5;
  localparam logic [31:0] MX_LEFT  = 32'h3af1de9b;
  localparam logic [31:0] MX_RIGHT = 32'h13a7ce59;

  // datapath operations, one per cycle
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_A1   = 4'd1;
  localparam logic [3:0] OP_A2   = 4'd2;
  localparam logic [3:0] OP_A3   = 4'd3;
  localparam logic [3:0] OP_A4   = 4'd4;
  localparam logic [3:0] OP_A5   = 4'd5;
  localparam logic [3:0] OP_A6   = 4'd6;
  localparam logic [3:0] OP_COMB = 4'd7;
  localparam logic [3:0] OP_MIX0 = 4'd8;
  localparam logic [3:0] OP_MIX1 = 4'd9;
  localparam logic [3:0] OP_MIX2 = 4'd10;
  localparam logic [3:0] OP_MIX3 = 4'd11;

  typedef struct packed {
    logic       load;  // capture input item
    logic [3:0] op;
  } bhash_ctrl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

FILE: hdl/bhash_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhash_if
// Valid/ready channels for input blocks and hash results.
// ----------------------------------------------------------------------------
interface bhash_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] word3;
  logic [31:0] length_term;
  logic        first;
  logic        last;

  modport source (output valid, word0, word1, word2, word3, length_term, first, last,
                  input ready);
  modport sink (input valid, word0, word1, word2, word3, length_term, first, last,
                output ready);
endinterface

interface bhash_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash0;
  logic [31:0] hash1;
  logic [31:0] hash2;
  logic [31:0] hash3;

  modport source (output valid, hash0, hash1, hash2, hash3, input ready);
  modport sink (input valid, hash0, hash1, hash2, hash3, output ready);
endinterface

FILE: hdl/block_hash_128_absorb_top.sv
`timescale 1ns / 1ps
// Block without last: accept plus six absorb products, then back to idle.
// Block with last: six absorb products, one combine, sixteen mixer products and
//   an output load that waits for room in the output register, then the next accept.
// Every product goes through one shared 32x32 multiplier, one per cycle in the absorb and mix phases.
// Synchronous active-low reset loads the seed constants and empties the output.
// ----------------------------------------------------------------------------
// block_hash_128_absorb_top
// Sequencer, input capture and output register of the 128-bit block hash.
// ----------------------------------------------------------------------------
`include "block_hash_128_absorb_top_assert.svh"

module block_hash_128_absorb_top
  import bhash_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bhash_in_if.sink          in_ch,
  bhash_out_if.source       out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ABS  = 3'd1;
  localparam logic [2:0] ST_COMB = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [3:0]  mix_cnt_r, mix_cnt_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] hash0_r, hash1_r, hash2_r, hash3_r;
  logic [31:0] dp_h0, dp_h1, dp_h2, dp_h3;
  logic        in_xfer, out_free, out_load;
  bhash_ctrl_t ctrl;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == ST_PUSH) && out_free;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    mix_cnt_nxt = mix_cnt_r;
    last_nxt    = last_r;
    ctrl.load   = 1'b0;
    ctrl.op     = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ctrl.load = 1'b1;
          last_nxt  = in_ch.last;
          step_nxt  = '0;
          state_nxt = ST_ABS;
        end
      end
      ST_ABS: begin
        case (step_r)
          3'd0:    ctrl.op = OP_A1;
          3'd1:    ctrl.op = OP_A2;
          3'd2:    ctrl.op = OP_A3;
          3'd3:    ctrl.op = OP_A4;
          3'd4:    ctrl.op = OP_A5;
          default: ctrl.op = OP_A6;
        endcase
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd5) begin
          state_nxt = last_r ? ST_COMB : ST_IDLE;
        end
      end
      ST_COMB: begin
        ctrl.op     = OP_COMB;
        mix_cnt_nxt = '0;
        state_nxt   = ST_MIX;
      end
      ST_MIX: begin
        case (mix_cnt_r[1:0])
          2'd0:    ctrl.op = OP_MIX0;
          2'd1:    ctrl.op = OP_MIX1;
          2'd2:    ctrl.op = OP_MIX2;
          default: ctrl.op = OP_MIX3;
        endcase
        mix_cnt_nxt = mix_cnt_r + 4'd1;
        if (mix_cnt_r == 4'd15) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // hold until the output register can take the hash
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  bhash_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .word0       (in_ch.word0),
    .word1       (in_ch.word1),
    .word2       (in_ch.word2),
    .word3       (in_ch.word3),
    .length_term (in_ch.length_term),
    .first       (in_ch.first),
    .hash0       (dp_h0),
    .hash1       (dp_h1),
    .hash2       (dp_h2),
    .hash3       (dp_h3)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      mix_cnt_r   <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      mix_cnt_r   <= mix_cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hash0_r <= dp_h0;
      hash1_r <= dp_h1;
      hash2_r <= dp_h2;
      hash3_r <= dp_h3;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.hash0 = hash0_r;
  assign out_ch.hash1 = hash1_r;
  assign out_ch.hash2 = hash2_r;
  assign out_ch.hash3 = hash3_r;

  // a transfer starts a multi-cycle absorb
  `BH_ASSERT_NXT(a_busy_after_xfer, in_xfer, !in_ch.ready)
  // mix counter only runs inside the mix phase
  `BH_ASSERT_IMP(a_mix_cnt_idle, state_r != ST_MIX, mix_cnt_r == 4'd0)
  // a push with room lands in the output register
  `BH_ASSERT_NXT(a_push_lands, out_load, out_valid_r && (state_r == ST_IDLE))

endmodule

FILE: hdl/bhash_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhash_mul
// Shared 32x32 multiplier, low 32 bits of the product (mod 2^32).
// ----------------------------------------------------------------------------
module bhash_mul (
  input  logic [31:0] mul_x,
  input  logic [31:0] mul_y,
  output logic [31:0] prod
);

  assign prod = mul_x * mul_y;

endmodule

FILE: hdl/bhash_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhash_dp
// Accumulators, block registers and finalize/mix registers around the
// shared multiplier. One op per cycle from the sequencer.
// ----------------------------------------------------------------------------
module bhash_dp
  import bhash_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  bhash_ctrl_t ctrl,
  input  logic [31:0] word0,
  input  logic [31:0] word1,
  input  logic [31:0] word2,
  input  logic [31:0] word3,
  input  logic [31:0] length_term,
  input  logic        first,
  output logic [31:0] hash0,
  output logic [31:0] hash1,
  output logic [31:0] hash2,
  output logic [31:0] hash3
);

  logic [31:0] acc_a_r, acc_b_r, acc_c_r, acc_d_r;
  logic [31:0] acc_a_nxt, acc_b_nxt, acc_c_nxt, acc_d_nxt;
  logic [31:0] t_r, t_nxt;
  logic [31:0] m0_r, m1_r, m2_r, m3_r, len_r;
  logic [31:0] f0_r, f1_r, f2_r, f3_r;
  logic [31:0] f0_nxt, f1_nxt, f2_nxt, f3_nxt;
  logic [31:0] mul_x, mul_y, prod;
  logic [31:0] comb_a, mix_v;

  bhash_mul u_mul (
    .mul_x (mul_x),
    .mul_y (mul_y),
    .prod  (prod)
  );

  // operand select
  always_comb begin
    mul_x = acc_b_r;
    mul_y = acc_c_r;
    case (ctrl.op)
      OP_A1: begin
        mul_x = rotr32(m0_r, 7);
        mul_y = K_A;
      end
      OP_A2: begin
        mul_x = acc_b_r;
        mul_y = rotl32(m1_r, 19) + acc_a_r;
      end
      OP_A3: begin
        mul_x = rotr32(m2_r, 3);
        mul_y = K_C;
      end
      OP_A4: begin
        mul_x = acc_b_r;
        mul_y = acc_c_r;
      end
      OP_A5: begin
        mul_x = rotr32(m3_r, 11);
        mul_y = acc_c_r;
      end
      OP_A6: begin
        mul_x = K_D;
        mul_y = acc_a_r;
      end
      OP_MIX0: begin
        mul_x = f0_r;
        mul_y = MX_MUL;
      end
      OP_MIX1: begin
        mul_x = MX_LEFT;
        mul_y = f0_r >> 13;
      end
      OP_MIX2: begin
        mul_x = f0_r;
        mul_y = rotr32(f0_r, 7);
      end
      OP_MIX3: begin
        mul_x = MX_RIGHT;
        mul_y = f0_r;
      end
      default: begin
        mul_x = acc_b_r;
        mul_y = acc_c_r;
      end
    endcase
  end

  assign comb_a = ((acc_a_r + acc_b_r) - acc_c_r) ^ acc_d_r;
  assign mix_v  = prod;

  // result write-back
  always_comb begin
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    acc_c_nxt = acc_c_r;
    acc_d_nxt = acc_d_r;
    t_nxt     = t_r;
    f0_nxt    = f0_r;
    f1_nxt    = f1_r;
    f2_nxt    = f2_r;
    f3_nxt    = f3_r;
    if (ctrl.load && first) begin
      acc_a_nxt = SEED_A;
      acc_b_nxt = SEED_B;
      acc_c_nxt = SEED_C;
      acc_d_nxt = SEED_D;
    end
    case (ctrl.op)
      OP_A1: acc_a_nxt = acc_a_r ^ (prod + len_r);
      OP_A2: acc_b_nxt = prod;
      OP_A3: t_nxt = prod;
      OP_A4: acc_c_nxt = acc_c_r + t_r + prod;
      OP_A5: t_nxt = prod;
      OP_A6: begin
        // last product plus the a <- d, c <- a, d <- c permute
        acc_a_nxt = acc_d_r ^ (t_r + prod);
        acc_c_nxt = acc_a_r;
        acc_d_nxt = acc_c_r;
      end
      OP_COMB: begin
        f0_nxt = comb_a;
        f1_nxt = acc_d_r + comb_a;
        f2_nxt = acc_c_r ^ comb_a;
        f3_nxt = acc_b_r - comb_a;
      end
      OP_MIX0: f0_nxt = mix_v ^ rotl32(mix_v, 11);
      OP_MIX1: f0_nxt = f0_r ^ (prod + MX_ADD);
      OP_MIX2: f0_nxt = prod;
      OP_MIX3: begin
        // word done: rotate so the next word sits in f0
        f0_nxt = f1_r;
        f1_nxt = f2_r;
        f2_nxt = f3_r;
        f3_nxt = f0_r ^ (prod << 17);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r <= SEED_A;
      acc_b_r <= SEED_B;
      acc_c_r <= SEED_C;
      acc_d_r <= SEED_D;
    end else begin
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
      acc_c_r <= acc_c_nxt;
      acc_d_r <= acc_d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r  <= t_nxt;
    f0_r <= f0_nxt;
    f1_r <= f1_nxt;
    f2_r <= f2_nxt;
    f3_r <= f3_nxt;
    if (ctrl.load) begin
      m0_r  <= word0;
      m1_r  <= word1;
      m2_r  <= word2;
      m3_r  <= word3;
      len_r <= length_term;
    end
  end

  assign hash0 = f0_r;
  assign hash1 = f1_r;
  assign hash2 = f2_r;
  assign hash3 = f3_r;

endmodule
